@@ hw/rtl/mlps_pkg.sv @@
// Shared types and constants for the motor link phase sequencer.
package mlps_pkg;

  localparam int unsigned HistoryDepthDef = 8;

  localparam logic [15:0] TimeoutReset = 16'd50;
  localparam logic [31:0] LeastReset   = 32'hffff_ffff;

  // Phase codes of the ten-phase request/reply cycle.
  localparam logic [3:0] PhaseReq0  = 4'd0;
  localparam logic [3:0] PhaseRep1  = 4'd1;
  localparam logic [3:0] PhaseReq2  = 4'd2;
  localparam logic [3:0] PhaseRep3  = 4'd3;
  localparam logic [3:0] PhaseReq4  = 4'd4;
  localparam logic [3:0] PhaseRep5  = 4'd5;
  localparam logic [3:0] PhaseReq6  = 4'd6;
  localparam logic [3:0] PhaseRep7  = 4'd7;
  localparam logic [3:0] PhaseSet8  = 4'd8;
  localparam logic [3:0] PhaseLast  = 4'd9;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        reply_arrived;
  } mlps_in_t;

  typedef struct packed {
    logic        reply_taken;
    logic [3:0]  reply_phase;
    logic        timed_out;
    logic        send_request;
    logic [3:0]  send_phase;
    logic [31:0] period_last;
    logic [31:0] period_least;
    logic [31:0] period_most;
    logic [31:0] period_mean;
  } mlps_out_t;

  // Classified pass handed from the front to the statistics back end.
  typedef struct packed {
    logic        reply_taken;
    logic [3:0]  reply_phase;
    logic        timed_out;
    logic        send_request;
    logic [3:0]  send_phase;
    logic        new_period;
    logic        record;
    logic [31:0] period;
  } mlps_cmd_t;

endpackage

@@ hw/rtl/motor_link_phase_sequencer_top.sv @@
// Top level of the motor link phase sequencer: front end, queue and back end.
//
// Each input word is one control-loop pass for a motor link: the current
// millisecond time and a flag for a received reply. The front end steps the
// ten-phase request/reply cycle (reply check, timeout, send) in the cycle the
// word is accepted and pushes a classified pass into a two-entry queue. The
// back end keeps the period statistics and returns exactly one output word
// per input word, in order.
// Throughput: a pass that records no new period goes through the queue and the
// output register, and such passes sustain one word per cycle while the receiver
// takes words and the divider is idle. A phase-0 pass with a nonzero period runs
// a serial restoring divider for the ring mean, one quotient bit per cycle over
// the 32 + log2(HISTORY_DEPTH) bit sum, and the back end takes no further pass
// until its word is loaded into the output register; the divider sets the rate.
// The configuration channel writes the 16-bit reply timeout; it is always
// ready; the user must write it only while the block is idle (not enforced).
// Reset clears the phase to 0, the timeout to 50 ms and all statistics; the
// history ring needs no clearing because a read entry counts only once the ring
// is full. When the receiver stalls, the output word holds, the queue fills
// and in_ready_o drops until the receiver takes words again.
module motor_link_phase_sequencer_top #(
  parameter int unsigned HISTORY_DEPTH = mlps_pkg::HistoryDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlps_pkg::mlps_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlps_pkg::mlps_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import mlps_pkg::*;

  // Queue handshake between the two halves.
  logic      q_full, q_push, q_empty, q_pop;
  mlps_cmd_t q_wdata, q_rdata;

  // The front end owns the phase, the cycle start time and the timeout.
  mlps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // The queue lets the front keep accepting while the divider is busy.
  mlps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  // The back end owns the statistics and the output register.
  mlps_back #(
    .HistoryDepth (HISTORY_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hw/rtl/mlps_front.sv @@
// Front end: phase state machine, timeout check and period measurement.
module mlps_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mlps_pkg::mlps_in_t in_data_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output mlps_pkg::mlps_cmd_t q_data_o
);
  import mlps_pkg::*;

  logic [3:0]  phase_q, phase_d, phase_mid;
  logic [31:0] start_q, start_d;
  logic [15:0] timeout_q;
  logic [31:0] elapsed;
  logic        odd_phase, send_phase_ok;
  mlps_cmd_t   cmd;

  assign in_ready_o  = !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign q_push_o    = in_valid_i && in_ready_o;
  assign q_data_o    = cmd;

  assign elapsed = in_data_i.now_ms - start_q;

  always_comb begin
    odd_phase = (phase_q == PhaseRep1) || (phase_q == PhaseRep3) ||
                (phase_q == PhaseRep5) || (phase_q == PhaseRep7);
    cmd       = '0;
    phase_mid = phase_q;
    start_d   = start_q;
    // Reply check first.
    if (odd_phase) begin
      if (in_data_i.reply_arrived) begin
        cmd.reply_taken = 1'b1;
        cmd.reply_phase = phase_q;
        phase_mid       = phase_q + 4'd1;
      end else if (elapsed > {16'd0, timeout_q}) begin
        cmd.timed_out = 1'b1;
        phase_mid     = PhaseReq0;
      end
    end
    // Then the send step on whatever phase the check left.
    send_phase_ok = (phase_mid == PhaseReq0) || (phase_mid == PhaseReq2) ||
                    (phase_mid == PhaseReq4) || (phase_mid == PhaseReq6) ||
                    (phase_mid == PhaseSet8) || (phase_mid == PhaseLast);
    phase_d = phase_mid;
    cmd.period = elapsed;
    if (send_phase_ok) begin
      cmd.send_request = 1'b1;
      cmd.send_phase   = phase_mid;
      if (phase_mid == PhaseReq0) begin
        cmd.new_period = 1'b1;
        cmd.record     = (elapsed != 32'd0);
        start_d        = in_data_i.now_ms;
      end
      phase_d = (phase_mid == PhaseLast) ? PhaseReq0 : phase_mid + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhaseReq0;
      start_q   <= '0;
      timeout_q <= TimeoutReset;
    end else begin
      if (q_push_o) begin
        phase_q <= phase_d;
        start_q <= start_d;
      end
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ hw/rtl/mlps_fifo.sv @@
// Two-entry queue between the front end and the statistics back end.
module mlps_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mlps_pkg::mlps_cmd_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output mlps_pkg::mlps_cmd_t data_o
);
  import mlps_pkg::*;

  mlps_cmd_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ hw/rtl/mlps_back.sv @@
// Back end: period statistics, history ring, serial mean divider, output register.
module mlps_back #(
  parameter int unsigned HistoryDepth = mlps_pkg::HistoryDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  mlps_pkg::mlps_cmd_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mlps_pkg::mlps_out_t out_data_o
);
  import mlps_pkg::*;

  localparam int unsigned SumW  = 32 + $clog2(HistoryDepth);
  localparam int unsigned FillW = $clog2(HistoryDepth + 1);
  localparam int unsigned SlotW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int unsigned CntW  = $clog2(SumW + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSum  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]       state_q, state_d;
  mlps_cmd_t        cmd_q;
  logic [31:0]      hist_mem [HistoryDepth];
  logic [31:0]      hist_rd_q;
  logic [SlotW-1:0] slot_q;
  logic [FillW-1:0] fill_q;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [31:0]      recent_q, least_q, most_q, mean_q;
  logic [SumW-1:0]  quo_q;
  logic [FillW:0]   rem_q, rem_sh;
  logic [CntW-1:0]  cnt_q;
  logic             div_ge;
  logic             ring_full;
  logic             out_free;
  logic             out_load;
  logic             rd_en, wr_en;
  mlps_out_t        out_q;
  logic             out_valid_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign ring_full   = (fill_q == FillW'(HistoryDepth));

  // A recording pass is popped only when the back end is idle; other passes
  // need a free output register as well.
  assign q_pop_o = (state_q == StIdle) && !q_empty_i &&
                   (q_data_i.record || out_free);
  assign rd_en   = q_pop_o && q_data_i.record;
  assign wr_en   = (state_q == StSum);

  // The output register takes a new word straight from the queue or from the
  // finished divider.
  assign out_load = (q_pop_o && !q_data_i.record) || ((state_q == StDone) && out_free);

  assign sum_d  = sum_q - (ring_full ? SumW'(hist_rd_q) : '0) + SumW'(cmd_q.period);
  assign rem_sh = {rem_q[FillW-1:0], quo_q[SumW-1]};
  assign div_ge = (rem_sh >= {1'b0, fill_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (rd_en) state_d = StSum;
      StSum:   state_d = StDiv;
      StDiv:   if (cnt_q == CntW'(SumW - 1)) state_d = StDone;
      StDone:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[slot_q] <= cmd_q.period;
    end
    if (rd_en) begin
      hist_rd_q <= hist_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_data_i;
    end
    if (state_q == StSum) begin
      quo_q <= sum_d;
      rem_q <= '0;
    end else if (state_q == StDiv) begin
      quo_q <= {quo_q[SumW-2:0], div_ge};
      rem_q <= div_ge ? (rem_sh - {1'b0, fill_q}) : rem_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      recent_q    <= '0;
      least_q     <= LeastReset;
      most_q      <= '0;
      mean_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (q_pop_o) begin
            if (q_data_i.new_period) begin
              recent_q <= q_data_i.period;
            end
            if (!q_data_i.record) begin
              out_q.reply_taken  <= q_data_i.reply_taken;
              out_q.reply_phase  <= q_data_i.reply_phase;
              out_q.timed_out    <= q_data_i.timed_out;
              out_q.send_request <= q_data_i.send_request;
              out_q.send_phase   <= q_data_i.send_phase;
              out_q.period_last  <= q_data_i.new_period ? q_data_i.period : recent_q;
              out_q.period_least <= least_q;
              out_q.period_most  <= most_q;
              out_q.period_mean  <= mean_q;
            end
          end
        end
        StSum: begin
          sum_q <= sum_d;
          if (least_q > cmd_q.period) least_q <= cmd_q.period;
          if (most_q < cmd_q.period) most_q <= cmd_q.period;
          slot_q <= (slot_q == SlotW'(HistoryDepth - 1)) ? '0 : slot_q + SlotW'(1);
          if (!ring_full) fill_q <= fill_q + FillW'(1);
          cnt_q <= '0;
        end
        StDiv: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(SumW - 1)) begin
            mean_q <= {quo_q[30:0], div_ge};
          end
        end
        StDone: begin
          if (out_free) begin
            out_q.reply_taken  <= cmd_q.reply_taken;
            out_q.reply_phase  <= cmd_q.reply_phase;
            out_q.timed_out    <= cmd_q.timed_out;
            out_q.send_request <= cmd_q.send_request;
            out_q.send_phase   <= cmd_q.send_phase;
            out_q.period_last  <= recent_q;
            out_q.period_least <= least_q;
            out_q.period_most  <= most_q;
            out_q.period_mean  <= mean_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the motor link phase sequencer top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlps_pkg::*;

  // The ring depth of the block under test; the predictor keeps a ring of the same size.
  localparam int unsigned HistDepth = HistoryDepthDef;
  // Random passes per timeout setting. Seven settings give about 1100 words in all.
  localparam int unsigned PhaseWords = 155;
  // Cycles with no handshake on any channel before the run is declared hung. The limit
  // leaves a wide margin over the divider run of a phase-0 word, the longest receiver
  // hold and the longest sender gap.
  localparam int unsigned IdleLimit = 2000;
  // Cycles allowed after the last expected word before the block counts as idle.
  localparam int unsigned SettleCycles = 60;
  // Mismatch lines printed before the report goes quiet and only counts.
  localparam int unsigned MaxPrinted = 60;
  // Value of reply_phase and send_phase when no reply was taken or nothing was sent.
  localparam logic [3:0] NoPhase = 4'd0;

  // Receiver behavior, picked anew for every window of cycles.
  typedef enum int {RxOpen, RxCoin, RxSparse, RxHold} rx_mode_e;

  // One row of the directed table: the input word and, where it is obvious, the
  // result typed in by hand.
  typedef struct packed {
    mlps_in_t  word;
    logic      pinned;
    mlps_out_t want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  mlps_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  mlps_out_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  // Predictor state: a copy of everything the block remembers between passes.
  logic [3:0]      link_phase = PhaseReq0;
  logic [31:0]     cyc_start = '0;
  logic [31:0]     least_ms = LeastReset;
  logic [31:0]     most_ms = '0;
  logic [31:0]     last_ms = '0;
  logic [31:0]     mean_ms = '0;
  logic [31:0]     ring [HistDepth];
  int unsigned     ring_slot = 0;
  int unsigned     ring_fill = 0;
  longint unsigned ring_sum = 0;
  logic [15:0]     timeout_ms = TimeoutReset;

  // Results still owed by the block, oldest first.
  mlps_out_t pending_passes [$];
  stim_row_t stim_tab [$];

  logic [31:0] last_now = '0;
  int unsigned burst_left = 0;
  int unsigned quiet = 0;
  int unsigned mismatches = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned timeouts_seen = 0;
  int unsigned replies_seen = 0;
  int unsigned settings_written = 0;
  int unsigned rx_win = 0;
  rx_mode_e    rx_mode = RxOpen;

  always #5 clk_i = ~clk_i;

  motor_link_phase_sequencer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic mlps_out_t pass_word(input logic taken, input logic [3:0] rph,
                                          input logic tout, input logic sent,
                                          input logic [3:0] sph, input logic [31:0] last,
                                          input logic [31:0] least, input logic [31:0] most,
                                          input logic [31:0] mean);
    mlps_out_t w;
    w.reply_taken  = taken;
    w.reply_phase  = rph;
    w.timed_out    = tout;
    w.send_request = sent;
    w.send_phase   = sph;
    w.period_last  = last;
    w.period_least = least;
    w.period_most  = most;
    w.period_mean  = mean;
    return w;
  endfunction

  // Steps the phase sequence for one loop pass and returns the word the block must
  // produce for it. The reply check runs first, then the send step of the same pass.
  task automatic sequence_pass(input mlps_in_t w, output mlps_out_t r);
    logic [31:0] dt;
    logic        taken;
    logic        tout;
    logic        sent;
    logic [3:0]  rph;
    logic [3:0]  sph;
    taken = 1'b0;
    tout  = 1'b0;
    sent  = 1'b0;
    rph   = NoPhase;
    sph   = NoPhase;
    // Time since the cycle started, modulo 2^32. It serves both as the reply wait and,
    // in phase 0, as the measured period.
    dt = w.now_ms - cyc_start;
    case (link_phase)
      PhaseRep1, PhaseRep3, PhaseRep5, PhaseRep7: begin
        if (w.reply_arrived) begin
          taken = 1'b1;
          rph = link_phase;
          link_phase = link_phase + 4'd1;
        end else if (dt > {16'd0, timeout_ms}) begin
          // The link dropped: fall back to phase 0, which sends in this same pass.
          tout = 1'b1;
          link_phase = PhaseReq0;
        end
      end
      default: ;
    endcase
    case (link_phase)
      PhaseReq0, PhaseReq2, PhaseReq4, PhaseReq6, PhaseSet8, PhaseLast: begin
        if (link_phase == PhaseReq0) begin
          last_ms = dt;
          cyc_start = w.now_ms;
          // A zero period leaves the extremes and the ring untouched.
          if (dt != 0) begin
            if (least_ms > dt) least_ms = dt;
            if (most_ms < dt) most_ms = dt;
            if (ring_fill == HistDepth) ring_sum -= ring[ring_slot];
            ring[ring_slot] = dt;
            ring_sum += dt;
            ring_slot = (ring_slot == HistDepth - 1) ? 0 : ring_slot + 1;
            if (ring_fill < HistDepth) ring_fill++;
            mean_ms = 32'(ring_sum / longint'(ring_fill));
          end
        end
        sent = 1'b1;
        sph = link_phase;
        link_phase = (link_phase == PhaseLast) ? PhaseReq0 : link_phase + 4'd1;
      end
      default: ;
    endcase
    r = pass_word(taken, rph, tout, sent, sph, last_ms, least_ms, most_ms, mean_ms);
  endtask

  task automatic add_row(input logic [31:0] now, input logic arrived, input logic pinned,
                         input mlps_out_t want);
    stim_row_t row;
    row.word.now_ms = now;
    row.word.reply_arrived = arrived;
    row.pinned = pinned;
    row.want = want;
    stim_tab.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t ns word %0d: %s is %h, expected %h", $realtime, words_out, what, got,
               want);
  endtask

  // Offers one word, waits until it is taken, records what must come back, and then
  // decides whether the sender pauses. Bursts of random length alternate with random
  // gaps, and some bursts run straight into the next one.
  task automatic send_pass(input mlps_in_t w, input logic pinned, input mlps_out_t pin_val,
                           input bit last);
    mlps_out_t   want;
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sequence_pass(w, want);
    if (pinned) want = pin_val;
    pending_passes.push_back(want);
    last_now = w.now_ms;
    words_in++;
    timeouts_seen += want.timed_out;
    replies_seen += want.reply_taken;
    gap = 0;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
    end
    if (last || gap > 0) in_valid_i <= 1'b0;
    if (!last) repeat (gap) @(posedge clk_i);
  endtask

  // Picks the time stamp of the next pass. Most passes move time forward a little; some
  // land exactly on or one past the timeout boundary, some repeat the time, and a few
  // jump anywhere in the 32-bit range or close to the wrap point.
  function automatic logic [31:0] pick_now();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return last_now;
    if (r < 75) return last_now + $urandom_range(1, 12);
    if (r < 88) return cyc_start + {16'd0, timeout_ms} + $urandom_range(0, 1);
    if (r < 95) return $urandom();
    return 32'hffff_ffff - $urandom_range(0, 20);
  endfunction

  task automatic run_random(input int unsigned count);
    mlps_in_t w;
    for (int unsigned i = 0; i < count; i++) begin
      w.now_ms = pick_now();
      // Replies mostly arrive; a missing one leaves the link waiting toward a timeout.
      w.reply_arrived = ($urandom_range(0, 99) < 70);
      send_pass(w, 1'b0, '0, i == count - 1);
    end
  endtask

  // Waits until every owed word is back, then lets the divider run out.
  task automatic settle();
    while (pending_passes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    timeout_ms = value;
    settings_written++;
  endtask

  // Receiver: each window of cycles gets a mode of its own, from always ready, through
  // coin flips and sparse acceptance, to a long hold that opens only near its end.
  always @(posedge clk_i) begin
    if (rx_win == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_win  <= $urandom_range(20, 80);
    end else begin
      rx_win <= rx_win - 1;
    end
    case (rx_mode)
      RxOpen:   out_ready_i <= 1'b1;
      RxCoin:   out_ready_i <= 1'($urandom_range(0, 1));
      RxSparse: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:  out_ready_i <= (rx_win < 8);
    endcase
  end

  // Every word the block hands over is compared, field by field, with the oldest owed
  // result.
  always @(posedge clk_i) begin : check_out
    mlps_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_passes.size() == 0) begin
        report_mismatch("word with nothing owed, period_last", out_data_o.period_last, '0);
      end else begin
        want = pending_passes.pop_front();
        if (out_data_o.reply_taken !== want.reply_taken)
          report_mismatch("reply_taken", 32'(out_data_o.reply_taken),
                          32'(want.reply_taken));
        if (out_data_o.reply_phase !== want.reply_phase)
          report_mismatch("reply_phase", 32'(out_data_o.reply_phase),
                          32'(want.reply_phase));
        if (out_data_o.timed_out !== want.timed_out)
          report_mismatch("timed_out", 32'(out_data_o.timed_out), 32'(want.timed_out));
        if (out_data_o.send_request !== want.send_request)
          report_mismatch("send_request", 32'(out_data_o.send_request),
                          32'(want.send_request));
        if (out_data_o.send_phase !== want.send_phase)
          report_mismatch("send_phase", 32'(out_data_o.send_phase), 32'(want.send_phase));
        if (out_data_o.period_last !== want.period_last)
          report_mismatch("period_last", out_data_o.period_last, want.period_last);
        if (out_data_o.period_least !== want.period_least)
          report_mismatch("period_least", out_data_o.period_least, want.period_least);
        if (out_data_o.period_most !== want.period_most)
          report_mismatch("period_most", out_data_o.period_most, want.period_most);
        if (out_data_o.period_mean !== want.period_mean)
          report_mismatch("period_mean", out_data_o.period_mean, want.period_mean);
      end
      words_out++;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet == IdleLimit) begin
      $display("no handshake for %0d cycles, %0d words still owed", IdleLimit,
               pending_passes.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [15:0] tmo_plan [6];
    tmo_plan = '{16'hffff, 16'd0, 16'd9, 16'($urandom_range(1, 65534)), 16'd1,
                 TimeoutReset};

    // Directed table, starting from reset with the default 50 ms timeout. The first
    // pass sees a zero period, so only the phase moves.
    add_row(32'd0, 1'b0, 1'b1,
            pass_word(1'b0, NoPhase, 1'b0, 1'b1, PhaseReq0, '0, LeastReset, '0, '0));
    // Reply in phase 1 is taken and the phase 2 request goes out in the same pass.
    add_row(32'd0, 1'b1, 1'b1,
            pass_word(1'b1, PhaseRep1, 1'b0, 1'b1, PhaseReq2, '0, LeastReset, '0, '0));
    // Waiting in phase 3: 10 ms, then exactly the timeout, which is not yet too long.
    add_row(32'd10, 1'b0, 1'b1,
            pass_word(1'b0, NoPhase, 1'b0, 1'b0, NoPhase, '0, LeastReset, '0, '0));
    add_row(32'd50, 1'b0, 1'b1,
            pass_word(1'b0, NoPhase, 1'b0, 1'b0, NoPhase, '0, LeastReset, '0, '0));
    // One millisecond past the timeout: the link drops and phase 0 records 51 ms.
    add_row(32'd51, 1'b0, 1'b1,
            pass_word(1'b0, NoPhase, 1'b1, 1'b1, PhaseReq0, 32'd51, 32'd51, 32'd51, 32'd51));
    // A full cycle with every reply present.
    add_row(32'd51, 1'b1, 1'b1,
            pass_word(1'b1, PhaseRep1, 1'b0, 1'b1, PhaseReq2, 32'd51, 32'd51, 32'd51, 32'd51));
    add_row(32'd52, 1'b1, 1'b1,
            pass_word(1'b1, PhaseRep3, 1'b0, 1'b1, PhaseReq4, 32'd51, 32'd51, 32'd51, 32'd51));
    add_row(32'd53, 1'b1, 1'b1,
            pass_word(1'b1, PhaseRep5, 1'b0, 1'b1, PhaseReq6, 32'd51, 32'd51, 32'd51, 32'd51));
    add_row(32'd54, 1'b1, 1'b1,
            pass_word(1'b1, PhaseRep7, 1'b0, 1'b1, PhaseSet8, 32'd51, 32'd51, 32'd51, 32'd51));
    // A reply in phase 9 is ignored; phase 9 sends and wraps to 0.
    add_row(32'd55, 1'b1, 1'b1,
            pass_word(1'b0, NoPhase, 1'b0, 1'b1, PhaseLast, 32'd51, 32'd51, 32'd51, 32'd51));
    // From here the predictor supplies the expectations: ignored reply in phase 0,
    // a short wait, a huge wait up to the top of the time range, and a wait across the
    // wrap point that must not count as a timeout.
    add_row(32'd55, 1'b1, 1'b0, '0);
    add_row(32'd56, 1'b0, 1'b0, '0);
    add_row(32'd56, 1'b1, 1'b0, '0);
    add_row(32'hffff_ffff, 1'b0, 1'b0, '0);
    add_row(32'd0, 1'b0, 1'b0, '0);
    add_row(32'd0, 1'b1, 1'b0, '0);
    add_row(32'd0, 1'b1, 1'b0, '0);
    add_row(32'd1, 1'b1, 1'b0, '0);
    add_row(32'd2, 1'b1, 1'b0, '0);
    add_row(32'd3, 1'b0, 1'b0, '0);
    add_row(32'd3, 1'b1, 1'b0, '0);
    add_row(32'd4, 1'b0, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The table runs straight into the random passes, so the sender keeps its valid.
    foreach (stim_tab[i])
      send_pass(stim_tab[i].word, stim_tab[i].pinned, stim_tab[i].want, 1'b0);

    // Random passes, first under the reset timeout, then under each further setting.
    // Settings change only once the block has gone idle.
    run_random(PhaseWords);
    foreach (tmo_plan[i]) begin
      write_timeout(tmo_plan[i]);
      run_random(PhaseWords);
    end
    settle();

    $display("covered %0d loop passes under %0d timeout settings after the default",
             words_in, settings_written);
    $display("%0d replies taken, %0d link drops, %0d words checked", replies_seen,
             timeouts_seen, words_out);
    if (mismatches == 0 && pending_passes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
